// ===== rtl/trss_pkg.sv =====
// Shared types, codes and constants for the Toeplitz receive-side scaling steering block.
// Used by the parser, the remainder step, the top level and the checker.
package trss_pkg;

    localparam int unsigned TABLE_SIZE_DEF = 32;
    localparam int unsigned HASH_W         = 32;
    localparam int unsigned KEY_W          = 128;
    localparam int unsigned REM_W          = 6;
    localparam int unsigned REM_STEPS      = 4;
    localparam int unsigned DIV_STAGES     = HASH_W / REM_STEPS;
    localparam int unsigned ENTRY_W        = 5;
    localparam int unsigned TAG_W          = 6;

    localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
    localparam logic [15:0] TPID_QINQ    = 16'h88A8;
    localparam logic [15:0] ETH_HDR_LEN  = 16'd14;
    localparam logic [15:0] TAG_LEN      = 16'd4;
    localparam logic [15:0] L3L4_LEN     = 16'd24;
    localparam logic [15:0] QINQ_MIN_LEN = 16'd18;

    typedef enum logic [1:0] {
        ACT_PASS     = 2'd0,
        ACT_NOT_IPV4 = 2'd1,
        ACT_STEER    = 2'd2,
        ACT_TBL_WR   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_KEY_VALID     = 2'd0,
        REG_KEY_HIGH      = 2'd1,
        REG_KEY_LOW       = 2'd2,
        REG_ACTIVE_QUEUES = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        action_t             action;
        logic [HASH_W-1:0]   part0;
        logic [HASH_W-1:0]   part1;
        logic [HASH_W-1:0]   part2;
        logic [ENTRY_W-1:0]  tidx;
        logic [ENTRY_W-1:0]  tval;
    } parse_t;

    typedef struct packed {
        action_t             action;
        logic [HASH_W-1:0]   hash;
        logic [REM_W-1:0]    rem;
        logic [ENTRY_W-1:0]  tidx;
        logic [ENTRY_W-1:0]  tval;
    } item_t;

    // Key bit j is bit KEY_W-1-j of the packed key; the window starts at key bit pos.
    function automatic logic [HASH_W-1:0] key_window(input logic [KEY_W-1:0] key,
                                                     input int unsigned pos);
        return key[KEY_W-1-pos -: HASH_W];
    endfunction

endpackage

// ===== rtl/toeplitz_rss_queue_steer.sv =====
// Top level of the Toeplitz receive-side scaling queue steering block.
// Depends on trss_pkg, trss_parse and trss_rem_step.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------
//  in      | sink      | in_valid / in_ready    | cmd .. table_value
//  out     | source    | out_valid / out_ready  | action, hash, queue_tag
//  cfg     | sink      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// There are twelve register stages, the first loaded at the accepting edge: decode and
// partial hash, hash combine, eight remainder stages of four bits each, table read,
// output. One transaction is accepted every cycle unless the output stalls; the
// remainder pipeline sets the depth. Each stage holds its item while the next one is
// full and cannot move on, so a stall at the output fills empty stages first and never
// drops or repeats a transaction.
// Reset clears key and valid bits and sets one active queue; no clearing pass is needed.
module toeplitz_rss_queue_steer
    import trss_pkg::*;
#(
    parameter int unsigned QUEUE_TABLE_SIZE = TABLE_SIZE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic        tag_present,
    input  logic [15:0] tag_proto,
    input  logic [15:0] outer_ethertype,
    input  logic [15:0] inner_ethertype,
    input  logic [15:0] frame_len,
    input  logic [31:0] ip_src,
    input  logic [31:0] ip_dst,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    input  logic [4:0]  table_index,
    input  logic [4:0]  table_value,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  action,
    output logic [31:0] hash,
    output logic [5:0]  queue_tag,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int unsigned IDX_W     = $clog2(QUEUE_TABLE_SIZE);
    localparam int unsigned MASK_W    = (IDX_W > REM_W) ? IDX_W : REM_W;
    localparam int unsigned TBL_STAGE = DIV_STAGES + 2;
    localparam int unsigned OUT_STAGE = TBL_STAGE + 1;

    logic               key_valid_reg;
    logic [63:0]        key_high_reg;
    logic [63:0]        key_low_reg;
    logic [REM_W-1:0]   active_queues_reg;
    logic [REM_W-1:0]   divisor;

    parse_t             pa_next;
    parse_t             pa_reg;
    item_t              st_reg [1:TBL_STAGE];
    logic [REM_W-1:0]   rem_out [DIV_STAGES];
    logic [OUT_STAGE:0] v_reg;
    logic [OUT_STAGE:0] adv;

    logic [ENTRY_W-1:0] mem [QUEUE_TABLE_SIZE];
    logic [QUEUE_TABLE_SIZE-1:0] tv_reg;
    logic [ENTRY_W-1:0] ent_reg;
    logic               ent_ok_reg;
    item_t              tsrc;
    logic               tbl_move;
    logic               wr_in_range;
    logic [IDX_W-1:0]   waddr;
    logic [IDX_W-1:0]   raddr;

    action_t            action_reg;
    logic [31:0]        hash_reg;
    logic [5:0]         queue_tag_reg;

    assign cfg_ready = 1'b1;
    assign divisor   = (active_queues_reg == '0) ? REM_W'(1) : active_queues_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_valid_reg     <= 1'b0;
            key_high_reg      <= '0;
            key_low_reg       <= '0;
            active_queues_reg <= REM_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KEY_VALID:     key_valid_reg     <= cfg_data[0];
                REG_KEY_HIGH:      key_high_reg      <= cfg_data;
                REG_KEY_LOW:       key_low_reg       <= cfg_data;
                REG_ACTIVE_QUEUES: active_queues_reg <= cfg_data[REM_W-1:0];
                default:           ;
            endcase
        end
    end

    trss_parse u_parse (
        .cmd             (cmd),
        .tag_present     (tag_present),
        .tag_proto       (tag_proto),
        .outer_ethertype (outer_ethertype),
        .inner_ethertype (inner_ethertype),
        .frame_len       (frame_len),
        .ip_src          (ip_src),
        .ip_dst          (ip_dst),
        .src_port        (src_port),
        .dst_port        (dst_port),
        .table_index     (table_index),
        .table_value     (table_value),
        .key_valid       (key_valid_reg),
        .key             ({key_high_reg, key_low_reg}),
        .res             (pa_next)
    );

    // A stage takes a new item when it is empty or its own item moves on.
    always_comb
    begin
        adv[OUT_STAGE] = !v_reg[OUT_STAGE] || out_ready;
        for (int i = OUT_STAGE - 1; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end

    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i <= OUT_STAGE; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_rem
        trss_rem_step #(
            .STEPS (REM_STEPS)
        ) u_rem_step (
            .divisor (divisor),
            .rem_in  (st_reg[g+1].rem),
            .bits    (st_reg[g+1].hash[HASH_W-1-g*REM_STEPS -: REM_STEPS]),
            .rem_out (rem_out[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            pa_reg <= pa_next;
        end
        if (adv[1])
        begin
            st_reg[1].action <= pa_reg.action;
            st_reg[1].hash   <= pa_reg.part0 ^ pa_reg.part1 ^ pa_reg.part2;
            st_reg[1].rem    <= '0;
            st_reg[1].tidx   <= pa_reg.tidx;
            st_reg[1].tval   <= pa_reg.tval;
        end
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            if (adv[i+2])
            begin
                st_reg[i+2].action <= st_reg[i+1].action;
                st_reg[i+2].hash   <= st_reg[i+1].hash;
                st_reg[i+2].rem    <= rem_out[i];
                st_reg[i+2].tidx   <= st_reg[i+1].tidx;
                st_reg[i+2].tval   <= st_reg[i+1].tval;
            end
        end
        if (adv[TBL_STAGE])
        begin
            st_reg[TBL_STAGE] <= st_reg[TBL_STAGE-1];
        end
    end

    assign tsrc        = st_reg[TBL_STAGE-1];
    assign tbl_move    = adv[TBL_STAGE] && v_reg[TBL_STAGE-1];
    assign wr_in_range = {27'd0, tsrc.tidx} < 32'(QUEUE_TABLE_SIZE);
    assign waddr       = IDX_W'(tsrc.tidx);
    assign raddr       = IDX_W'(MASK_W'(tsrc.rem) & MASK_W'(QUEUE_TABLE_SIZE - 1));

    always_ff @(posedge clk)
    begin
        if (tbl_move)
        begin
            if (tsrc.action == ACT_TBL_WR)
            begin
                if (wr_in_range)
                begin
                    mem[waddr] <= tsrc.tval;
                end
            end
            else
            begin
                ent_reg <= mem[raddr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg     <= '0;
            ent_ok_reg <= 1'b0;
        end
        else if (tbl_move)
        begin
            if (tsrc.action == ACT_TBL_WR)
            begin
                if (wr_in_range)
                begin
                    tv_reg[waddr] <= 1'b1;
                end
            end
            else
            begin
                ent_ok_reg <= tv_reg[raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[OUT_STAGE])
        begin
            action_reg <= st_reg[TBL_STAGE].action;
            if (st_reg[TBL_STAGE].action == ACT_STEER)
            begin
                hash_reg      <= st_reg[TBL_STAGE].hash;
                queue_tag_reg <= {1'b0, (ent_ok_reg ? ent_reg : ENTRY_W'(0))} + TAG_W'(1);
            end
            else
            begin
                hash_reg      <= '0;
                queue_tag_reg <= '0;
            end
        end
    end

    assign out_valid = v_reg[OUT_STAGE];
    assign action    = action_reg;
    assign hash      = hash_reg;
    assign queue_tag = queue_tag_reg;

endmodule

// ===== rtl/trss_parse.sv =====
// Header decode and Toeplitz partial hashes, one per 32-bit word of the 4-tuple.
// Depends on trss_pkg.
module trss_parse
    import trss_pkg::*;
(
    input  logic                cmd,
    input  logic                tag_present,
    input  logic [15:0]         tag_proto,
    input  logic [15:0]         outer_ethertype,
    input  logic [15:0]         inner_ethertype,
    input  logic [15:0]         frame_len,
    input  logic [31:0]         ip_src,
    input  logic [31:0]         ip_dst,
    input  logic [15:0]         src_port,
    input  logic [15:0]         dst_port,
    input  logic [4:0]          table_index,
    input  logic [4:0]          table_value,
    input  logic                key_valid,
    input  logic [KEY_W-1:0]    key,
    output parse_t              res
);

    logic        qinq;
    logic [15:0] proto;
    logic [15:0] min_len;
    logic [31:0] ports;

    assign qinq    = tag_present && (tag_proto == TPID_QINQ);
    assign proto   = qinq ? inner_ethertype : outer_ethertype;
    assign min_len = ETH_HDR_LEN + L3L4_LEN + (qinq ? TAG_LEN : 16'd0);
    assign ports   = {src_port, dst_port};

    always_comb
    begin
        res.tidx  = table_index;
        res.tval  = table_value;
        res.part0 = '0;
        res.part1 = '0;
        res.part2 = '0;
        if (cmd)
        begin
            res.action = ACT_TBL_WR;
        end
        else if (!key_valid)
        begin
            res.action = ACT_PASS;
        end
        else if (qinq && (frame_len < QINQ_MIN_LEN))
        begin
            res.action = ACT_PASS;
        end
        else if (proto != ETYPE_IPV4)
        begin
            res.action = ACT_NOT_IPV4;
        end
        else if (frame_len < min_len)
        begin
            res.action = ACT_PASS;
        end
        else
        begin
            res.action = ACT_STEER;
        end
        for (int b = 0; b < HASH_W; b++)
        begin
            if (ip_src[HASH_W-1-b])
            begin
                res.part0 = res.part0 ^ key_window(key, b);
            end
            if (ip_dst[HASH_W-1-b])
            begin
                res.part1 = res.part1 ^ key_window(key, HASH_W + b);
            end
            if (ports[HASH_W-1-b])
            begin
                res.part2 = res.part2 ^ key_window(key, 2*HASH_W + b);
            end
        end
    end

endmodule

// ===== rtl/trss_rem_step.sv =====
// A few steps of restoring remainder by a 6-bit divisor, one hash bit per step.
// Depends on trss_pkg.
module trss_rem_step
    import trss_pkg::*;
#(
    parameter int unsigned STEPS = REM_STEPS
)
(
    input  logic [REM_W-1:0] divisor,
    input  logic [REM_W-1:0] rem_in,
    input  logic [STEPS-1:0] bits,
    output logic [REM_W-1:0] rem_out
);

    always_comb
    begin
        logic [REM_W:0] trial;
        logic [REM_W-1:0] r;
        r = rem_in;
        for (int s = 0; s < STEPS; s++)
        begin
            trial = {r, bits[STEPS-1-s]};
            if (trial >= {1'b0, divisor})
            begin
                trial = trial - {1'b0, divisor};
            end
            r = trial[REM_W-1:0];
        end
        rem_out = r;
    end

endmodule

// ===== rtl/trss_checker.sv =====
// Port-level checks for the steering block, attached to the top level by a bind.
// Depends on trss_pkg and toeplitz_rss_queue_steer.
module trss_checker
    import trss_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  action,
    input logic [31:0] hash,
    input logic [5:0]  queue_tag
);

    // A result that is not taken keeps its whole payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action) && $stable(hash)
                                    && $stable(queue_tag))
        else $error("result changed while stalled");

    a_unsteered_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action != ACT_STEER) |-> (hash == '0) && (queue_tag == '0))
        else $error("hash or queue tag set on an unsteered transaction");

    a_steer_tag_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == ACT_STEER) |-> (queue_tag != '0))
        else $error("steered transaction without a queue tag");

    a_steer_tag_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == ACT_STEER) |-> (queue_tag <= 6'd32))
        else $error("queue tag beyond the table value range");

endmodule

bind toeplitz_rss_queue_steer trss_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .action    (action),
    .hash      (hash),
    .queue_tag (queue_tag)
);
